[design/kpht_pkg.sv]
// Package for the key press/hold/release tracker: item types, message codes,
// key phase type and the small helper functions used by the tracker.
// No dependencies.
`default_nettype none

package kpht_pkg;

    // Number of tracked keys and the width of a key address.
    localparam int NUM_KEYS = 256;
    localparam int KEY_AW   = $clog2(NUM_KEYS);

    typedef logic [KEY_AW-1:0] t_key_addr;

    // Item function codes.
    localparam logic [1:0] FN_EVENT       = 2'd0;
    localparam logic [1:0] FN_FRAME_START = 2'd1;
    localparam logic [1:0] FN_FRAME_END   = 2'd2;
    localparam logic [1:0] FN_QUERY       = 2'd3;

    // Window message kinds.
    localparam logic [3:0] MSG_OTHER    = 4'd0;
    localparam logic [3:0] MSG_LEFT_DN  = 4'd1;
    localparam logic [3:0] MSG_LEFT_UP  = 4'd2;
    localparam logic [3:0] MSG_RIGHT_DN = 4'd3;
    localparam logic [3:0] MSG_RIGHT_UP = 4'd4;
    localparam logic [3:0] MSG_MID_DN   = 4'd5;
    localparam logic [3:0] MSG_MID_UP   = 4'd6;
    localparam logic [3:0] MSG_EXTRA_DN = 4'd7;
    localparam logic [3:0] MSG_EXTRA_UP = 4'd8;
    localparam logic [3:0] MSG_KEY_DN   = 4'd9;
    localparam logic [3:0] MSG_KEY_UP   = 4'd10;
    localparam logic [3:0] MSG_SYS_DN   = 4'd11;
    localparam logic [3:0] MSG_SYS_UP   = 4'd12;
    localparam logic [3:0] MSG_WHEEL    = 4'd13;
    localparam logic [3:0] MSG_MOVE     = 4'd14;
    localparam logic [3:0] MSG_CHAR     = 4'd15;

    // Extra button selectors.
    localparam logic [1:0] XB_FIRST  = 2'd1;
    localparam logic [1:0] XB_SECOND = 2'd2;

    // Key numbers that the mouse buttons drive.
    localparam t_key_addr KEY_LEFT  = t_key_addr'(1);
    localparam t_key_addr KEY_RIGHT = t_key_addr'(2);
    localparam t_key_addr KEY_MID   = t_key_addr'(4);
    localparam t_key_addr KEY_X1    = t_key_addr'(5);
    localparam t_key_addr KEY_X2    = t_key_addr'(6);

    typedef enum logic [1:0] {
        PH_NONE     = 2'd0,
        PH_PRESSED  = 2'd1,
        PH_HELD     = 2'd2,
        PH_RELEASED = 2'd3
    } t_phase;

    typedef struct packed {
        logic [1:0]         func;
        logic [3:0]         msg_kind;
        logic [7:0]         key_code;
        logic [1:0]         extra_button;
        logic signed [15:0] wheel_step;
        logic [15:0]        pointer_x;
        logic [15:0]        pointer_y;
        logic [8:0]         query_key;
    } t_in_item;

    typedef struct packed {
        logic        key_pressed;
        logic        key_held;
        logic        key_released;
        logic        wheel_up;
        logic        wheel_down;
        logic [15:0] pointer_x_now;
        logic [15:0] pointer_y_now;
        logic [7:0]  typed_char;
    } t_out_item;

    typedef struct packed {
        logic pressed;
        logic held;
        logic released;
    } t_flags;

    // Write request to the key level store.
    typedef struct packed {
        logic      we;
        t_key_addr addr;
        logic      level;
    } t_lvl_wr;

    // Write request to the key phase store.
    typedef struct packed {
        logic      we;
        t_key_addr addr;
        t_phase    phase;
    } t_ph_wr;

    // Frame-start phase step of one key.
    function automatic t_phase next_phase(logic level, t_phase phase);
        logic active;
        active = (phase == PH_PRESSED) || (phase == PH_HELD);
        if (level) begin
            return active ? PH_HELD : PH_PRESSED;
        end
        return active ? PH_RELEASED : PH_NONE;
    endfunction

    function automatic t_flags phase_flags(t_phase phase);
        t_flags f;
        f.pressed  = (phase == PH_PRESSED);
        f.held     = (phase == PH_PRESSED) || (phase == PH_HELD);
        f.released = (phase == PH_RELEASED);
        return f;
    endfunction

    // Wheel sum with saturation to the signed 32-bit range.
    function automatic logic signed [31:0] wheel_add(logic signed [31:0] acc,
                                                     logic signed [15:0] step);
        logic signed [32:0] sum;
        sum = {acc[31], acc} + {{17{step[15]}}, step};
        if (sum[32] != sum[31]) begin
            return sum[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end
        return sum[31:0];
    endfunction

endpackage

`default_nettype wire

[design/kpht_chan_if.sv]
// Valid/ready channel interfaces for the tracker's input items and results.
// Depends on kpht_pkg.
`default_nettype none

interface kpht_in_if;
    import kpht_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface kpht_out_if;
    import kpht_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[design/key_press_hold_release_tracker.sv]
// Key press/hold/release tracker: one result transfer for every input item,
// showing the state after that item. Depends on kpht_pkg, kpht_chan_if and
// kpht_key_store.
//
// Window events and frame-end ticks go from input transfer to S_RESULT and
// key queries to S_QUERY, where the registered read of the phase memory
// arrives; from there the result is loaded into the output register. A
// frame-start tick walks the phase memory one key per cycle. After reset
// the block runs a clearing pass over both key memories, during which it
// takes no input. A new input item can be taken while the previous result
// still waits in the output register; the block works on one item at a
// time.
`default_nettype none

module key_press_hold_release_tracker (
    input  wire           i_clk,
    input  wire           i_rst_n,
    kpht_in_if.sink       i_item,
    kpht_out_if.source    o_result
);
    import kpht_pkg::*;

    // Control sequencer states.
    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_QUERY  = 5'b00100,
        S_WALK   = 5'b01000,
        S_RESULT = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    t_key_addr          r_cnt, n_cnt;
    logic signed [31:0] r_wheel_accum;
    logic signed [31:0] r_wheel_frame;
    logic [15:0]        r_ptr_x;
    logic [15:0]        r_ptr_y;
    logic [7:0]         r_char;
    logic               r_q_ok;
    t_flags             r_flags, n_flags;
    logic               r_out_valid;
    t_out_item          r_out;

    t_in_item  in;
    logic      acc;
    logic      slot_free;
    logic      fin;
    logic      walk_last;
    t_flags    fin_flags;
    t_lvl_wr   lvl_wr;
    t_ph_wr    ph_wr;
    t_key_addr rd_addr;
    logic      rd_level;
    t_phase    rd_phase;
    logic      code_ok;

    assign in        = i_item.payload;
    assign acc       = i_item.valid && i_item.ready;
    assign slot_free = !r_out_valid || o_result.ready;
    assign code_ok   = int'(in.key_code) < NUM_KEYS;
    assign walk_last = (r_state == S_WALK) && (r_cnt == t_key_addr'(NUM_KEYS - 1));

    // Items are taken only between items; the output register decouples the
    // result side, so a waiting result does not hold off the next transfer.
    assign i_item.ready = (r_state == S_IDLE);

    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    kpht_key_store u_store (
        .i_clk      (i_clk),
        .i_lvl_wr   (lvl_wr),
        .i_ph_wr    (ph_wr),
        .i_rd_addr  (rd_addr),
        .o_rd_level (rd_level),
        .o_rd_phase (rd_phase)
    );

    // Level writes come straight from window events at their transfer, or
    // from the clearing pass. Mouse buttons map onto fixed key numbers.
    always_comb begin
        lvl_wr.we    = 1'b0;
        lvl_wr.addr  = t_key_addr'(in.key_code);
        lvl_wr.level = 1'b0;
        if (r_state == S_CLEAR) begin
            lvl_wr.we   = 1'b1;
            lvl_wr.addr = r_cnt;
        end else if (acc && in.func == FN_EVENT) begin
            case (in.msg_kind)
                MSG_LEFT_DN, MSG_LEFT_UP: begin
                    lvl_wr.we    = 1'b1;
                    lvl_wr.addr  = KEY_LEFT;
                    lvl_wr.level = (in.msg_kind == MSG_LEFT_DN);
                end
                MSG_RIGHT_DN, MSG_RIGHT_UP: begin
                    lvl_wr.we    = 1'b1;
                    lvl_wr.addr  = KEY_RIGHT;
                    lvl_wr.level = (in.msg_kind == MSG_RIGHT_DN);
                end
                MSG_MID_DN, MSG_MID_UP: begin
                    lvl_wr.we    = 1'b1;
                    lvl_wr.addr  = KEY_MID;
                    lvl_wr.level = (in.msg_kind == MSG_MID_DN);
                end
                MSG_EXTRA_DN, MSG_EXTRA_UP: begin
                    // An extra-button event that names neither button is dropped.
                    lvl_wr.we    = (in.extra_button == XB_FIRST) ||
                                   (in.extra_button == XB_SECOND);
                    lvl_wr.addr  = (in.extra_button == XB_FIRST) ? KEY_X1 : KEY_X2;
                    lvl_wr.level = (in.msg_kind == MSG_EXTRA_DN);
                end
                MSG_KEY_DN, MSG_KEY_UP, MSG_SYS_DN, MSG_SYS_UP: begin
                    lvl_wr.we    = code_ok;
                    lvl_wr.level = (in.msg_kind == MSG_KEY_DN) ||
                                   (in.msg_kind == MSG_SYS_DN);
                end
                default: begin
                    lvl_wr.we = 1'b0;
                end
            endcase
        end
    end

    // Phase writes: the clearing pass, or the frame walk writing back the
    // entry whose read data arrives this cycle.
    always_comb begin
        ph_wr.we    = (r_state == S_CLEAR) || (r_state == S_WALK);
        ph_wr.addr  = r_cnt;
        ph_wr.phase = (r_state == S_WALK) ? next_phase(rd_level, rd_phase) : PH_NONE;
    end

    // Read address: the queried key at transfer, key zero at the start of a
    // walk, and the next key while walking. The walk reads one entry ahead of
    // its write-back, so a read and a write never meet on the same key.
    always_comb begin
        if (r_state == S_IDLE) begin
            rd_addr = (in.func == FN_FRAME_START) ? '0 : t_key_addr'(in.query_key);
        end else begin
            rd_addr = r_cnt + 1'b1;
        end
    end

    // An item is finished after its query read, at the last key of a walk, or
    // in S_RESULT, where events and ticks go and a finished item waits for the output register.
    always_comb begin
        fin_flags = '0;
        if (r_state == S_QUERY) begin
            fin_flags = r_q_ok ? phase_flags(rd_phase) : '0;
        end else if (r_state == S_RESULT) begin
            fin_flags = r_flags;
        end
        fin = (r_state == S_QUERY) || walk_last || (r_state == S_RESULT);
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_flags = r_flags;
        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == t_key_addr'(NUM_KEYS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_flags = '0;
                    n_cnt   = '0;
                    case (in.func)
                        FN_QUERY:       n_state = S_QUERY;
                        FN_FRAME_START: n_state = S_WALK;
                        default:        n_state = S_RESULT;
                    endcase
                end
            end
            S_WALK: begin
                n_cnt = r_cnt + 1'b1;
            end
            S_QUERY, S_RESULT: begin
                n_cnt = r_cnt;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (fin) begin
            n_flags = fin_flags;
            n_state = slot_free ? S_IDLE : S_RESULT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_cnt         <= '0;
            r_flags       <= '0;
            r_q_ok        <= 1'b0;
            r_wheel_accum <= '0;
            r_wheel_frame <= '0;
            r_ptr_x       <= '0;
            r_ptr_y       <= '0;
            r_char        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_flags <= n_flags;
            if (acc) begin
                r_q_ok <= int'(in.query_key) < NUM_KEYS;
                case (in.func)
                    FN_EVENT: begin
                        if (in.msg_kind == MSG_WHEEL) begin
                            r_wheel_accum <= wheel_add(r_wheel_accum, in.wheel_step);
                        end
                        if (in.msg_kind == MSG_MOVE) begin
                            r_ptr_x <= in.pointer_x;
                            r_ptr_y <= in.pointer_y;
                        end
                        if (in.msg_kind == MSG_CHAR) begin
                            r_char <= in.key_code;
                        end
                    end
                    FN_FRAME_START: begin
                        r_wheel_frame <= r_wheel_accum;
                        r_wheel_accum <= '0;
                    end
                    FN_FRAME_END: begin
                        r_char <= '0;
                    end
                    default: begin
                        r_char <= r_char;
                    end
                endcase
            end
            if (fin && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload; the shared fields are taken from the stored state at
    // the moment the result is loaded, which is after the item took effect.
    always_ff @(posedge i_clk) begin
        if (fin && slot_free) begin
            r_out.key_pressed   <= fin_flags.pressed;
            r_out.key_held      <= fin_flags.held;
            r_out.key_released  <= fin_flags.released;
            r_out.wheel_up      <= !r_wheel_frame[31] && (r_wheel_frame != '0);
            r_out.wheel_down    <= r_wheel_frame[31];
            r_out.pointer_x_now <= r_ptr_x;
            r_out.pointer_y_now <= r_ptr_y;
            r_out.typed_char    <= r_char;
        end
    end

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> !i_item.ready)
        else $error("input taken while an item is still in work");

    a_frame_wheel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && in.func == FN_FRAME_START |=> r_wheel_accum == '0 && r_state == S_WALK)
        else $error("frame start did not clear the wheel sum or start the walk");

    a_walk_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_WALK && $past(r_state == S_WALK) |->
            r_cnt == t_key_addr'($past(r_cnt) + 1'b1))
        else $error("frame walk skipped or repeated a key");

    a_flag_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.key_held && r_out.key_released) &&
                        (!r_out.key_pressed || r_out.key_held))
        else $error("result flags do not match any key phase");
`endif

endmodule

`default_nettype wire

[design/kpht_key_store.sv]
// Per-key storage: a level memory and a phase memory, each with one write
// port and one registered read port. Depends on kpht_pkg.
`default_nettype none

module kpht_key_store (
    input  wire                  i_clk,
    input  kpht_pkg::t_lvl_wr    i_lvl_wr,
    input  kpht_pkg::t_ph_wr     i_ph_wr,
    input  kpht_pkg::t_key_addr  i_rd_addr,
    output logic                 o_rd_level,
    output kpht_pkg::t_phase     o_rd_phase
);
    import kpht_pkg::*;

    logic   mem_level [NUM_KEYS];
    t_phase mem_phase [NUM_KEYS];

    always_ff @(posedge i_clk) begin
        if (i_lvl_wr.we) begin
            mem_level[i_lvl_wr.addr] <= i_lvl_wr.level;
        end
        o_rd_level <= mem_level[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ph_wr.we) begin
            mem_phase[i_ph_wr.addr] <= i_ph_wr.phase;
        end
        o_rd_phase <= mem_phase[i_rd_addr];
    end

endmodule

`default_nettype wire

[tb/sv/key_press_hold_release_tracker_tb.sv]
// Self-checking testbench for the key press/hold/release tracker.
// Depends on kpht_pkg, the kpht_chan_if channel interfaces and the tracker RTL.
`default_nettype none

module key_press_hold_release_tracker_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import kpht_pkg::*;

    // Number of random items, the wheel clamp limits, the drain time at the
    // end and the overall timeout.
    localparam int     RANDOM_ITEMS = 1900;
    localparam int     DRAIN_CYCLES = 20;
    localparam int     CYCLE_LIMIT  = 4_000_000;
    localparam longint WHEEL_MAX    = 2147483647;
    localparam longint WHEEL_MIN    = -longint'(2147483647) - 1;

    logic i_clk;
    logic i_rst_n;

    kpht_in_if  item_ch ();
    kpht_out_if result_ch ();

    key_press_hold_release_tracker DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // Mirror of the tracker state, advanced once per accepted input transfer.
    logic   key_down_mirror [NUM_KEYS];
    t_phase key_phase_mirror [NUM_KEYS];
    longint wheel_running;
    longint wheel_latched;
    logic [15:0] pointer_x_mirror;
    logic [15:0] pointer_y_mirror;
    logic [7:0]  char_mirror;

    // Results still owed by the block, oldest first.
    t_out_item pending_results [$];

    int mismatch_count = 0;
    int items_sent     = 0;
    int cycle_count    = 0;

    // When set, the sender inserts gaps and the receiver stalls in random bursts.
    bit idle_on = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Applies one item to the mirrored state and returns the result that the
    // block must produce for it. The result reflects the state after the item.
    function automatic t_out_item apply_to_tracker(t_in_item it);
        t_out_item r;
        longint    sum;
        logic      down;
        r    = '0;
        down = 1'b0;
        case (it.func)
            FN_EVENT: begin
                case (it.msg_kind)
                    MSG_LEFT_DN:  key_down_mirror[KEY_LEFT]  = 1'b1;
                    MSG_LEFT_UP:  key_down_mirror[KEY_LEFT]  = 1'b0;
                    MSG_RIGHT_DN: key_down_mirror[KEY_RIGHT] = 1'b1;
                    MSG_RIGHT_UP: key_down_mirror[KEY_RIGHT] = 1'b0;
                    MSG_MID_DN:   key_down_mirror[KEY_MID]   = 1'b1;
                    MSG_MID_UP:   key_down_mirror[KEY_MID]   = 1'b0;
                    MSG_EXTRA_DN, MSG_EXTRA_UP: begin
                        // Selector values other than first and second are ignored.
                        down = (it.msg_kind == MSG_EXTRA_DN);
                        if (it.extra_button == XB_FIRST) begin
                            key_down_mirror[KEY_X1] = down;
                        end else if (it.extra_button == XB_SECOND) begin
                            key_down_mirror[KEY_X2] = down;
                        end
                    end
                    MSG_KEY_DN, MSG_SYS_DN, MSG_KEY_UP, MSG_SYS_UP: begin
                        down = (it.msg_kind == MSG_KEY_DN) || (it.msg_kind == MSG_SYS_DN);
                        if (it.key_code < NUM_KEYS) begin
                            key_down_mirror[it.key_code] = down;
                        end
                    end
                    MSG_WHEEL: begin
                        // The running sum clamps at both ends of the 32-bit range.
                        sum = wheel_running + longint'($signed(it.wheel_step));
                        if (sum > WHEEL_MAX) begin
                            sum = WHEEL_MAX;
                        end
                        if (sum < WHEEL_MIN) begin
                            sum = WHEEL_MIN;
                        end
                        wheel_running = sum;
                    end
                    MSG_MOVE: begin
                        pointer_x_mirror = it.pointer_x;
                        pointer_y_mirror = it.pointer_y;
                    end
                    MSG_CHAR: char_mirror = it.key_code;
                    default: ;
                endcase
            end
            FN_FRAME_START: begin
                // A key that is down moves on to pressed and then held; a key
                // that is up reports released for one frame and then nothing.
                for (int k = 0; k < NUM_KEYS; k++) begin
                    case (key_phase_mirror[k])
                        PH_PRESSED, PH_HELD: begin
                            key_phase_mirror[k] = key_down_mirror[k] ? PH_HELD : PH_RELEASED;
                        end
                        default: begin
                            key_phase_mirror[k] = key_down_mirror[k] ? PH_PRESSED : PH_NONE;
                        end
                    endcase
                end
                wheel_latched = wheel_running;
                wheel_running = 0;
            end
            FN_FRAME_END: char_mirror = 8'h00;
            default: begin
                // Key query. Indexes past the last key report no flags.
                if (it.query_key < NUM_KEYS) begin
                    case (key_phase_mirror[it.query_key])
                        PH_PRESSED: begin
                            r.key_pressed = 1'b1;
                            r.key_held    = 1'b1;
                        end
                        PH_HELD:     r.key_held     = 1'b1;
                        PH_RELEASED: r.key_released = 1'b1;
                        default: ;
                    endcase
                end
            end
        endcase
        r.wheel_up      = (wheel_latched > 0);
        r.wheel_down    = (wheel_latched < 0);
        r.pointer_x_now = pointer_x_mirror;
        r.pointer_y_now = pointer_y_mirror;
        r.typed_char    = char_mirror;
        return r;
    endfunction

    // An item with every field random; callers overwrite what matters.
    function automatic t_in_item noise_item();
        logic [95:0] bits;
        t_in_item    it;
        bits = {$urandom, $urandom, $urandom};
        it   = bits[$bits(t_in_item)-1:0];
        return it;
    endfunction

    // Key and button traffic concentrates on keys 0 to 7, which hold all the
    // mouse buttons, so that keys go through their phases often.
    function automatic t_in_item random_event();
        t_in_item it;
        it          = noise_item();
        it.func     = FN_EVENT;
        it.msg_kind = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) != 0) begin
            it.key_code = 8'($urandom_range(0, 7));
        end
        return it;
    endfunction

    function automatic t_in_item query_item();
        t_in_item it;
        it      = noise_item();
        it.func = FN_QUERY;
        if ($urandom_range(0, 3) != 0) begin
            it.query_key = 9'($urandom_range(0, 7));
        end
        return it;
    endfunction

    // Offers one item and waits for its transfer; the expected result is
    // recorded at the edge where the transfer happens.
    task automatic send_item(input t_in_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        do @(posedge i_clk); while (!item_ch.ready);
        pending_results.push_back(apply_to_tracker(it));
        items_sent++;
    endtask

    task automatic send_event(input logic [3:0] kind, input logic [7:0] code,
                              input logic [1:0] xb);
        t_in_item it;
        it              = noise_item();
        it.func         = FN_EVENT;
        it.msg_kind     = kind;
        it.key_code     = code;
        it.extra_button = xb;
        send_item(it);
    endtask

    task automatic send_wheel(input logic signed [15:0] step);
        t_in_item it;
        it            = noise_item();
        it.func       = FN_EVENT;
        it.msg_kind   = MSG_WHEEL;
        it.wheel_step = step;
        send_item(it);
    endtask

    task automatic send_move(input logic [15:0] x, input logic [15:0] y);
        t_in_item it;
        it           = noise_item();
        it.func      = FN_EVENT;
        it.msg_kind  = MSG_MOVE;
        it.pointer_x = x;
        it.pointer_y = y;
        send_item(it);
    endtask

    task automatic send_query(input logic [8:0] key);
        t_in_item it;
        it           = noise_item();
        it.func      = FN_QUERY;
        it.query_key = key;
        send_item(it);
    endtask

    task automatic send_tick(input logic [1:0] fn);
        t_in_item it;
        it      = noise_item();
        it.func = fn;
        send_item(it);
    endtask

    // Pointer at both extremes, a character, and its clearing by frame end.
    task automatic test_pointer_and_char();
        send_move(16'hFFFF, 16'hFFFF);
        send_event(MSG_CHAR, 8'hFF, 2'd0);
        send_tick(FN_FRAME_END);
        send_move(16'h0000, 16'h0000);
    endtask

    // Down messages for every button and key, up messages for some of them, the ignored
    // extra-button selectors, the other message, and queries both inside and past the key range.
    task automatic test_buttons_and_keys();
        send_event(MSG_LEFT_DN, 8'h00, 2'd0);
        send_event(MSG_RIGHT_DN, 8'h00, 2'd0);
        send_event(MSG_MID_DN, 8'h00, 2'd0);
        send_event(MSG_EXTRA_DN, 8'h00, XB_FIRST);
        send_event(MSG_EXTRA_DN, 8'h00, XB_SECOND);
        send_event(MSG_EXTRA_DN, 8'h00, 2'd0);
        send_event(MSG_EXTRA_DN, 8'h00, 2'd3);
        send_event(MSG_KEY_DN, 8'hFF, 2'd0);
        send_event(MSG_SYS_DN, 8'h00, 2'd0);
        send_event(MSG_OTHER, 8'h03, 2'd0);
        send_wheel(16'sh8000);
        send_tick(FN_FRAME_START);
        send_query(9'd1);
        send_query(9'd255);
        send_query(9'd256);
        send_query(9'd511);
        send_event(MSG_KEY_UP, 8'hFF, 2'd0);
        send_event(MSG_SYS_UP, 8'h00, 2'd0);
        send_event(MSG_LEFT_UP, 8'h00, 2'd0);
        send_event(MSG_EXTRA_UP, 8'h00, XB_FIRST);
        send_tick(FN_FRAME_START);
        send_query(9'd255);
        send_query(9'd2);
    endtask

    // Wheel sums that end negative, positive and zero, each latched by a
    // frame start. The extreme steps nearly cancel, so the sign comes from
    // the one-unit difference between them.
    task automatic test_wheel_sign();
        idle_on = 1'b0;
        send_tick(FN_FRAME_START);
        repeat (4) send_wheel(16'sh7FFF);
        repeat (4) send_wheel(16'sh8000);
        send_tick(FN_FRAME_START);
        repeat (3) send_wheel(16'sh0001);
        send_tick(FN_FRAME_START);
        send_tick(FN_FRAME_START);
    endtask

    // Mostly well-formed frames with random content: a frame start, a mix of
    // events and queries, queries at the end and sometimes a frame end. Now
    // and then a short burst of fully random items breaks the pattern. Idling
    // is switched per frame and is off for the final stretch.
    task automatic test_random_frames();
        int first;
        int left;
        first = items_sent;
        while (items_sent - first < RANDOM_ITEMS) begin
            left    = RANDOM_ITEMS - (items_sent - first);
            idle_on = (left > 300) && ($urandom_range(0, 2) != 0);
            if ($urandom_range(0, 7) == 0) begin
                repeat ($urandom_range(1, 4)) send_item(noise_item());
            end else begin
                send_tick(FN_FRAME_START);
                repeat ($urandom_range(3, 12)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_item(query_item());
                    end else begin
                        send_item(random_event());
                    end
                end
                repeat ($urandom_range(1, 5)) send_item(query_item());
                if ($urandom_range(0, 1) == 1) begin
                    send_tick(FN_FRAME_END);
                end
            end
        end
        idle_on = 1'b0;
    endtask

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_down_mirror[k]  = 1'b0;
            key_phase_mirror[k] = PH_NONE;
        end
        wheel_running    = 0;
        wheel_latched    = 0;
        pointer_x_mirror = '0;
        pointer_y_mirror = '0;
        char_mirror      = '0;

        i_rst_n         <= 1'b0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block runs its clearing pass first; send_item simply waits on
        // ready until that is over.
        idle_on = 1'b1;
        test_pointer_and_char();
        test_buttons_and_keys();
        test_wheel_sign();
        test_random_frames();

        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Result side: ready drops in random bursts while idling is on.
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    task automatic compare_field(input string fname, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %h actual %h", $time, fname, want, got);
        end
    endtask

    // Each result transfer is matched against the oldest expected result.
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            got = result_ch.payload;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result transfer expected none actual %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                compare_field("key_pressed", want.key_pressed, got.key_pressed);
                compare_field("key_held", want.key_held, got.key_held);
                compare_field("key_released", want.key_released, got.key_released);
                compare_field("wheel_up", want.wheel_up, got.wheel_up);
                compare_field("wheel_down", want.wheel_down, got.wheel_down);
                compare_field("pointer_x_now", want.pointer_x_now, got.pointer_x_now);
                compare_field("pointer_y_now", want.pointer_y_now, got.pointer_y_now);
                compare_field("typed_char", want.typed_char, got.typed_char);
            end
        end
    end

    // Guards against a hang anywhere in the run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

endmodule

`default_nettype wire
